>>> hdl/ssfb_pkg.sv
// ----------------------------------------------------------------------------
// ssfb_pkg
// Types, command codes, driver command bytes and the segment table shared by
// the frame builder modules.
// ----------------------------------------------------------------------------
package ssfb_pkg;

  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_OFF    = 2'd1;
  localparam logic [1:0] CMD_ON     = 2'd2;
  localparam logic [1:0] CMD_UPDATE = 2'd3;

  localparam logic [7:0] BYTE_AUTO_INCR = 8'h40;
  localparam logic [7:0] BYTE_ADDR0     = 8'hC0;
  localparam logic [7:0] BYTE_DISP_OFF  = 8'h80;
  localparam logic [7:0] BYTE_DISP_ON   = 8'h88;
  localparam logic [7:0] SEG_ZERO       = 8'h3F;
  localparam logic [7:0] SEG_DASH       = 8'h40;
  localparam logic [7:0] SEG_BAD        = 8'hFF;

  // ceil(2^22 / 60): exact quotient for any 16-bit dividend
  localparam logic [16:0] RECIP_60   = 17'd69906;
  localparam int          RECIP_SH60 = 22;
  // ceil(2^11 / 10): exact quotient for dividends up to 255
  localparam logic [7:0]  RECIP_10   = 8'd205;
  localparam int          RECIP_SH10 = 11;

  localparam int MAX_BYTES = 7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] seconds;
    logic [7:0]  level;
    logic        blank_mode;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last;
  } out_t;

  // command attributes that ride along the time split
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] lvl;        // clamped level, zero means stored brightness
    logic       blank_mode;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [10:0] quo;
    logic [15:0] secs;
  } stb_t;

  typedef struct packed {
    ctl_t       ctl;
    logic [7:0] min;
    logic [5:0] sec;
  } stc_t;

  typedef struct packed {
    ctl_t       ctl;
    logic [7:0] min;
    logic [5:0] sec;
    logic [4:0] min_t;
    logic [2:0] sec_t;
  } std_t;

  function automatic logic [7:0] seg_of(input logic [4:0] d);
    logic [7:0] s;
    begin
      case (d)
        5'd0:    s = 8'h3F;
        5'd1:    s = 8'h06;
        5'd2:    s = 8'h5B;
        5'd3:    s = 8'h4F;
        5'd4:    s = 8'h66;
        5'd5:    s = 8'h6D;
        5'd6:    s = 8'h7D;
        5'd7:    s = 8'h07;
        5'd8:    s = 8'h7F;
        5'd9:    s = 8'h6F;
        default: s = SEG_BAD;
      endcase
      return s;
    end
  endfunction

endpackage

>>> hdl/seven_segment_timer_frame_builder.sv
// ----------------------------------------------------------------------------
// seven_segment_timer_frame_builder
// Turns display commands into the byte frames of a four-digit LED driver.
// ----------------------------------------------------------------------------
// Flow: a command passes the input register, the minutes/seconds split, the
// tens digits and the frame register; its bytes (1, 5 or 7) then leave the
// registered result ports on consecutive cycles, one byte per cycle, and a new
// command is taken every cycle while the byte shifter keeps up.
// Reset: pipeline and frame empty, stored brightness 7.
module seven_segment_timer_frame_builder (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ssfb_pkg::in_t  item,
  output logic           busy,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_data,
  output logic           result_strobe,
  output ssfb_pkg::out_t result
);
  import ssfb_pkg::*;

  logic       adv;
  logic       c_vld;
  stc_t       c;
  logic       d_vld;
  std_t       d;
  logic [2:0] brightness;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 3'd7;
    end else if (cfg_we) begin
      brightness <= cfg_data;
    end
  end

  ssfb_minsec u_minsec (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .start (start),
    .item  (item),
    .busy  (busy),
    .c_vld (c_vld),
    .c     (c)
  );

  ssfb_digits u_digits (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .c_vld (c_vld),
    .c     (c),
    .d_vld (d_vld),
    .d     (d)
  );

  ssfb_sequencer u_seq (
    .clk           (clk),
    .rst           (rst),
    .d_vld         (d_vld),
    .d             (d),
    .brightness    (brightness),
    .adv           (adv),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

>>> hdl/ssfb_minsec.sv
// ----------------------------------------------------------------------------
// ssfb_minsec
// Input register and the seconds-to-minutes split: reciprocal multiply by
// 1/60, then the remainder seconds, over three register stages.
// ----------------------------------------------------------------------------
module ssfb_minsec (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           start,
  input  ssfb_pkg::in_t  item,
  output logic           busy,
  output logic           c_vld,
  output ssfb_pkg::stc_t c
);
  import ssfb_pkg::*;

  logic        a_vld;
  in_t         a;
  logic        b_vld;
  stb_t        b;
  logic        load_a;
  logic        accept;
  logic [32:0] prod;
  logic [15:0] q60;
  logic [15:0] rem_s;
  ctl_t        ctl_next;

  assign busy   = a_vld & ~adv;
  assign accept = start & ~busy;
  assign load_a = adv | ~a_vld;

  always_comb begin
    prod = {17'd0, a.seconds} * {16'd0, RECIP_60};
    ctl_next.cmd        = a.cmd;
    ctl_next.blank_mode = a.blank_mode;
    if (a.level > 8'd7) begin
      ctl_next.lvl = 3'd7;
    end else begin
      ctl_next.lvl = a.level[2:0];
    end
  end

  // q*60 as (q<<6) - (q<<2)
  assign q60   = {b.quo[9:0], 6'd0} - {3'd0, b.quo, 2'd0};
  assign rem_s = b.secs - q60;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      if (load_a) begin
        a_vld <= accept;
      end
      if (adv) begin
        b_vld <= a_vld;
        c_vld <= b_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a <= item;
    end
    if (adv) begin
      b.ctl  <= ctl_next;
      b.quo  <= prod[32:RECIP_SH60];
      b.secs <= a.seconds;
      c.ctl  <= b.ctl;
      c.min  <= b.quo[7:0];
      c.sec  <= rem_s[5:0];
    end
  end

  a_busy_has_item: assert property (@(posedge clk) disable iff (rst) busy |-> a_vld)
    else $error("busy without a held item");
  a_sec_range: assert property (@(posedge clk) disable iff (rst) c_vld |-> c.sec < 6'd60)
    else $error("seconds remainder out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (c_vld && !adv) |=> (c_vld && $stable(c)))
    else $error("stalled stage changed");

endmodule

>>> hdl/ssfb_digits.sv
// ----------------------------------------------------------------------------
// ssfb_digits
// Tens digits of minutes and seconds by reciprocal multiply by 1/10.
// ----------------------------------------------------------------------------
module ssfb_digits (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           c_vld,
  input  ssfb_pkg::stc_t c,
  output logic           d_vld,
  output ssfb_pkg::std_t d
);
  import ssfb_pkg::*;

  logic [15:0] pm;
  logic [13:0] ps;

  assign pm = {8'd0, c.min} * {8'd0, RECIP_10};
  assign ps = {8'd0, c.sec} * {6'd0, RECIP_10};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d.ctl   <= c.ctl;
      d.min   <= c.min;
      d.sec   <= c.sec;
      d.min_t <= pm[15:RECIP_SH10];
      d.sec_t <= ps[13:RECIP_SH10];
    end
  end

  a_tens_range: assert property (@(posedge clk) disable iff (rst)
    d_vld |-> (d.min_t < 5'd26 && d.sec_t < 3'd6))
    else $error("tens digit out of range");

endmodule

>>> hdl/ssfb_sequencer.sv
// ----------------------------------------------------------------------------
// ssfb_sequencer
// Builds the byte frame of a command and shifts it out one byte per cycle
// through a registered output.
// ----------------------------------------------------------------------------
module ssfb_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           d_vld,
  input  ssfb_pkg::std_t d,
  input  logic [2:0]     brightness,
  output logic           adv,
  output logic           result_strobe,
  output ssfb_pkg::out_t result
);
  import ssfb_pkg::*;

  out_t       frm [MAX_BYTES];
  out_t       bld [MAX_BYTES];
  logic [2:0] rem;
  logic [2:0] bld_n;
  logic       load;
  logic [7:0] mo_w;
  logic [5:0] so_w;
  logic [7:0] fill;
  logic [2:0] lv;

  // the frame register frees up on the cycle its last byte goes out
  assign adv  = (rem == 3'd0) || (rem == 3'd1);
  assign load = adv & d_vld;

  assign mo_w = d.min - ({d.min_t[4:0], 3'd0} + {2'd0, d.min_t, 1'b0});
  assign so_w = d.sec - ({d.sec_t, 3'd0} + {2'd0, d.sec_t, 1'b0});
  assign fill = d.ctl.blank_mode ? SEG_DASH : SEG_ZERO;
  assign lv   = (d.ctl.lvl == 3'd0) ? brightness : d.ctl.lvl;

  always_comb begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      bld[i] = '0;
    end
    bld_n = 3'd1;
    unique case (d.ctl.cmd)
      CMD_INIT: begin
        bld_n  = 3'd7;
        bld[0] = '{BYTE_AUTO_INCR, 1'b1, 1'b1, 1'b0};
        bld[1] = '{BYTE_ADDR0, 1'b1, 1'b0, 1'b0};
        bld[2] = '{fill, 1'b0, 1'b0, 1'b0};
        bld[3] = '{fill, 1'b0, 1'b0, 1'b0};
        bld[4] = '{fill, 1'b0, 1'b0, 1'b0};
        bld[5] = '{fill, 1'b0, 1'b1, 1'b0};
        bld[6] = '{BYTE_DISP_ON | {5'd0, brightness}, 1'b1, 1'b1, 1'b1};
      end
      CMD_OFF: begin
        bld[0] = '{BYTE_DISP_OFF, 1'b1, 1'b1, 1'b1};
      end
      CMD_ON: begin
        bld[0] = '{BYTE_DISP_ON | {5'd0, lv}, 1'b1, 1'b1, 1'b1};
      end
      CMD_UPDATE: begin
        bld_n  = 3'd5;
        bld[0] = '{BYTE_ADDR0, 1'b1, 1'b0, 1'b0};
        bld[1] = '{seg_of(d.min_t), 1'b0, 1'b0, 1'b0};
        bld[2] = '{seg_of({1'b0, mo_w[3:0]}), 1'b0, 1'b0, 1'b0};
        bld[3] = '{seg_of({2'd0, d.sec_t}), 1'b0, 1'b0, 1'b0};
        bld[4] = '{seg_of({1'b0, so_w[3:0]}), 1'b0, 1'b1, 1'b1};
      end
      default: begin
        bld_n = 3'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem           <= 3'd0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (rem != 3'd0);
      if (load) begin
        rem <= bld_n;
      end else if (rem != 3'd0) begin
        rem <= rem - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rem != 3'd0) begin
      result <= frm[0];
    end
    if (load) begin
      frm <= bld;
    end else begin
      for (int i = 0; i < MAX_BYTES - 1; i++) begin
        frm[i] <= frm[i + 1];
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (rem == 3'd0 || rem == 3'd1))
    else $error("frame loaded over unsent bytes");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (rem == 3'd0) |=> !result_strobe)
    else $error("transfer with empty frame");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |-> result.frame_end)
    else $error("last byte without stop");

endmodule
